FILE: rtl/gcdr_pkg.sv
// Package for the GPU command dirty-rectangle tracker.
// Holds the word types, the opcode codes and the coordinate helpers.
// Depends on nothing; every other file in rtl uses it.
package gcdr_pkg;

    localparam int DEF_VRAM_WIDTH  = 1024;
    localparam int DEF_VRAM_HEIGHT = 512;

    localparam int COORD_W   = 14;
    localparam int MAX_WORDS = 16;

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam logic [7:0] OP_FILL         = 8'h02;
    localparam logic [7:0] OP_POLY_LO      = 8'h20;
    localparam logic [7:0] OP_POLY_HI      = 8'h3F;
    localparam logic [7:0] OP_LINE_LO      = 8'h40;
    localparam logic [7:0] OP_LINE_HI      = 8'h5F;
    localparam logic [7:0] OP_RECT_LO      = 8'h60;
    localparam logic [7:0] OP_RECT_HI      = 8'h7F;
    localparam logic [7:0] OP_COPY_LO      = 8'h80;
    localparam logic [7:0] OP_COPY_HI      = 8'h9F;
    localparam logic [7:0] OP_UPLOAD_LO    = 8'hA0;
    localparam logic [7:0] OP_UPLOAD_HI    = 8'hBF;
    localparam logic [7:0] OP_AREA_TL      = 8'hE3;
    localparam logic [7:0] OP_AREA_BR      = 8'hE4;
    localparam logic [7:0] OP_DRAW_OFFSET  = 8'hE5;

    typedef struct packed {
        logic        port;
        logic [4:0]  pkt_words;
        logic [31:0] command;
        logic [31:0] word_one;
        logic [31:0] word_two;
        logic [31:0] word_three;
        logic [31:0] word_four;
        logic [31:0] word_five;
        logic [31:0] word_six;
        logic [31:0] word_seven;
    } t_in_word;

    typedef struct packed {
        logic        writes_vram;
        logic        cpu_upload;
        logic        rect_valid;
        logic [9:0]  rect_x;
        logic [8:0]  rect_y;
        logic [10:0] rect_w;
        logic [9:0]  rect_h;
    } t_out_word;

    typedef struct packed {
        logic        capture;
        logic [9:0]  clip_left;
        logic [8:0]  clip_top;
        logic [9:0]  clip_right;
        logic [8:0]  clip_bottom;
        logic [10:0] offset_x;
        logic [10:0] offset_y;
    } t_draw_state;

    function automatic t_coord sext11(logic [10:0] v);
        return t_coord'({{(COORD_W-11){v[10]}}, v});
    endfunction

    // Vertex x and y: 11-bit signed coordinate plus the signed draw offset.
    function automatic t_coord vert_x(logic [31:0] w, logic [10:0] off);
        return sext11(w[10:0]) + sext11(off);
    endfunction

    function automatic t_coord vert_y(logic [31:0] w, logic [10:0] off);
        return sext11(w[26:16]) + sext11(off);
    endfunction

    function automatic logic [4:0] sat_count(logic [4:0] c);
        return (c > 5'(MAX_WORDS)) ? 5'(MAX_WORDS) : c;
    endfunction

    // A word is acted on only with capture on, on the drawing port, and non-empty.
    function automatic logic item_live(t_in_word d, logic capture);
        return capture && !d.port && (d.pkt_words != 5'd0);
    endfunction

endpackage

FILE: rtl/gcdr_state.sv
// Draw state of the dirty-rectangle tracker: capture enable, draw area
// corners and draw offset. Uses gcdr_pkg for the state struct and opcodes.
module gcdr_state #(
    parameter int VRAM_WIDTH  = gcdr_pkg::DEF_VRAM_WIDTH,
    parameter int VRAM_HEIGHT = gcdr_pkg::DEF_VRAM_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  i_step,
    input  gcdr_pkg::t_in_word    i_word,
    output gcdr_pkg::t_draw_state o_state
);

    gcdr_pkg::t_draw_state r_state;
    gcdr_pkg::t_draw_state n_state;
    logic [7:0]            op;

    assign op = i_word.command[31:24];

    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state.capture = i_cfg_wdata;
        end
        if (i_step && gcdr_pkg::item_live(i_word, r_state.capture)) begin
            case (op)
                gcdr_pkg::OP_AREA_TL: begin
                    n_state.clip_left = i_word.command[9:0];
                    n_state.clip_top  = i_word.command[18:10];
                end
                gcdr_pkg::OP_AREA_BR: begin
                    n_state.clip_right  = i_word.command[9:0];
                    n_state.clip_bottom = i_word.command[18:10];
                end
                gcdr_pkg::OP_DRAW_OFFSET: begin
                    n_state.offset_x = i_word.command[10:0];
                    n_state.offset_y = i_word.command[21:11];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.capture     <= 1'b0;
            r_state.clip_left   <= '0;
            r_state.clip_top    <= '0;
            r_state.clip_right  <= 10'(VRAM_WIDTH - 1);
            r_state.clip_bottom <= 9'(VRAM_HEIGHT - 1);
            r_state.offset_x    <= '0;
            r_state.offset_y    <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

FILE: rtl/gcdr_rect.sv
// Classifies one command word and finds the rectangle it touches.
// Purely combinational; uses gcdr_pkg for types, opcodes and coordinate helpers.
module gcdr_rect #(
    parameter int VRAM_WIDTH  = gcdr_pkg::DEF_VRAM_WIDTH,
    parameter int VRAM_HEIGHT = gcdr_pkg::DEF_VRAM_HEIGHT
) (
    input  gcdr_pkg::t_in_word    i_word,
    input  gcdr_pkg::t_draw_state i_state,
    output gcdr_pkg::t_out_word   o_result
);

    localparam gcdr_pkg::t_coord VW  = gcdr_pkg::t_coord'(VRAM_WIDTH);
    localparam gcdr_pkg::t_coord VH  = gcdr_pkg::t_coord'(VRAM_HEIGHT);
    localparam gcdr_pkg::t_coord ONE = gcdr_pkg::t_coord'(1);

    logic [7:0]       op;
    logic [4:0]       cnt;
    logic             live;
    logic             is_poly, is_line, is_rect, is_copy, is_upload;
    logic             mod, ok, clip;
    gcdr_pkg::t_coord x0, y0, x1, y1;
    gcdr_pkg::t_coord cx0, cy0, cx1, cy1;
    gcdr_pkg::t_coord mx0, my0, mx1, my1;
    gcdr_pkg::t_coord span_w, span_h;
    logic             valid;

    assign op        = i_word.command[31:24];
    assign cnt       = gcdr_pkg::sat_count(i_word.pkt_words);
    assign live      = gcdr_pkg::item_live(i_word, i_state.capture);
    assign is_poly   = (op >= gcdr_pkg::OP_POLY_LO) && (op <= gcdr_pkg::OP_POLY_HI);
    assign is_line   = (op >= gcdr_pkg::OP_LINE_LO) && (op <= gcdr_pkg::OP_LINE_HI);
    assign is_rect   = (op >= gcdr_pkg::OP_RECT_LO) && (op <= gcdr_pkg::OP_RECT_HI);
    assign is_copy   = (op >= gcdr_pkg::OP_COPY_LO) && (op <= gcdr_pkg::OP_COPY_HI);
    assign is_upload = (op >= gcdr_pkg::OP_UPLOAD_LO) && (op <= gcdr_pkg::OP_UPLOAD_HI);
    assign mod       = live && ((op == gcdr_pkg::OP_FILL) || is_poly || is_line || is_rect
                                || is_copy || is_upload);

    // Per-class corner extraction.
    always_comb begin
        logic [31:0]      wb, wc, wl, ws, pos, siz;
        logic [4:0]       need;
        logic [10:0]      fw_raw, sw;
        logic [9:0]       sh;
        gcdr_pkg::t_coord ax, ay, bx, by, vx, vy;
        gcdr_pkg::t_coord w, h;

        x0   = '0;
        y0   = '0;
        x1   = '0;
        y1   = '0;
        ok   = 1'b0;
        clip = 1'b0;

        // Polygon vertex words, spaced by one, two or three words.
        case ({op[4], op[2]})
            2'b00: begin
                wb = i_word.word_two;
                wc = i_word.word_three;
                need = 5'd4;
            end
            2'b01, 2'b10: begin
                wb = i_word.word_three;
                wc = i_word.word_five;
                need = 5'd6;
            end
            default: begin
                wb = i_word.word_four;
                wc = i_word.word_seven;
                need = 5'd8;
            end
        endcase
        wl = op[4] ? i_word.word_three : i_word.word_two;
        ws = op[2] ? i_word.word_three : i_word.word_two;

        ax = gcdr_pkg::vert_x(i_word.word_one, i_state.offset_x);
        ay = gcdr_pkg::vert_y(i_word.word_one, i_state.offset_y);

        fw_raw = {1'b0, i_word.word_two[9:0]} + 11'd15;
        pos = is_copy ? i_word.word_two : i_word.word_one;
        siz = is_copy ? i_word.word_three : i_word.word_two;
        sw  = (siz[9:0] == 10'd0) ? 11'h400 : {1'b0, siz[9:0]};
        sh  = (siz[24:16] == 9'd0) ? 10'h200 : {1'b0, siz[24:16]};
        bx = '0;
        by = '0;
        vx = '0;
        vy = '0;
        w  = '0;
        h  = '0;

        if (op == gcdr_pkg::OP_FILL) begin
            w  = gcdr_pkg::t_coord'({3'b0, fw_raw[10:4], 4'b0});
            h  = gcdr_pkg::t_coord'({5'b0, i_word.word_two[24:16]});
            x0 = gcdr_pkg::t_coord'({4'b0, i_word.word_one[9:4], 4'b0});
            y0 = gcdr_pkg::t_coord'({4'b0, i_word.word_one[25:16]});
            x1 = x0 + w - ONE;
            y1 = y0 + h - ONE;
            ok = (cnt >= 5'd3) && (w != '0) && (h != '0) && (x1 < VW) && (y1 < VH);
        end else if (is_poly) begin
            bx = gcdr_pkg::vert_x(wb, i_state.offset_x);
            by = gcdr_pkg::vert_y(wb, i_state.offset_y);
            vx = gcdr_pkg::vert_x(wc, i_state.offset_x);
            vy = gcdr_pkg::vert_y(wc, i_state.offset_y);
            x0 = (ax < bx) ? ax : bx;
            x0 = (vx < x0) ? vx : x0;
            x1 = (ax > bx) ? ax : bx;
            x1 = (vx > x1) ? vx : x1;
            y0 = (ay < by) ? ay : by;
            y0 = (vy < y0) ? vy : y0;
            y1 = (ay > by) ? ay : by;
            y1 = (vy > y1) ? vy : y1;
            ok   = (cnt >= need);
            clip = 1'b1;
        end else if (is_line) begin
            bx = gcdr_pkg::vert_x(wl, i_state.offset_x);
            by = gcdr_pkg::vert_y(wl, i_state.offset_y);
            x0 = (ax < bx) ? ax : bx;
            x1 = (ax < bx) ? bx : ax;
            y0 = (ay < by) ? ay : by;
            y1 = (ay < by) ? by : ay;
            // Polylines have no fixed length, so they give no rectangle.
            ok   = !op[3] && (cnt > (op[4] ? 5'd3 : 5'd2));
            clip = 1'b1;
        end else if (is_rect) begin
            case (op[4:3])
                2'd1: begin
                    w = gcdr_pkg::t_coord'(1);
                    h = gcdr_pkg::t_coord'(1);
                end
                2'd2: begin
                    w = gcdr_pkg::t_coord'(8);
                    h = gcdr_pkg::t_coord'(8);
                end
                2'd3: begin
                    w = gcdr_pkg::t_coord'(16);
                    h = gcdr_pkg::t_coord'(16);
                end
                default: begin
                    w = gcdr_pkg::t_coord'({4'b0, ws[9:0]});
                    h = gcdr_pkg::t_coord'({5'b0, ws[24:16]});
                end
            endcase
            x0 = ax;
            y0 = ay;
            x1 = x0 + w - ONE;
            y1 = y0 + h - ONE;
            ok = (cnt >= 5'd2)
                 && ((op[4:3] != 2'd0) || (cnt > (op[2] ? 5'd3 : 5'd2)));
            clip = 1'b1;
        end else if ((is_copy && (cnt >= 5'd4)) || (is_upload && (cnt >= 5'd3))) begin
            x0 = gcdr_pkg::t_coord'({4'b0, pos[9:0]});
            y0 = gcdr_pkg::t_coord'({4'b0, pos[25:16]});
            x1 = x0 + gcdr_pkg::t_coord'({3'b0, sw}) - ONE;
            y1 = y0 + gcdr_pkg::t_coord'({4'b0, sh}) - ONE;
            ok = (x1 < VW) && (y1 < VH);
        end
    end

    // Clip polygons, lines and rectangles to the draw area, add the margin, clamp to VRAM.
    always_comb begin
        cx0 = x0;
        cy0 = y0;
        cx1 = x1;
        cy1 = y1;
        if (clip) begin
            if (x0 < gcdr_pkg::t_coord'({4'b0, i_state.clip_left}))
                cx0 = gcdr_pkg::t_coord'({4'b0, i_state.clip_left});
            if (y0 < gcdr_pkg::t_coord'({5'b0, i_state.clip_top}))
                cy0 = gcdr_pkg::t_coord'({5'b0, i_state.clip_top});
            if (x1 > gcdr_pkg::t_coord'({4'b0, i_state.clip_right}))
                cx1 = gcdr_pkg::t_coord'({4'b0, i_state.clip_right});
            if (y1 > gcdr_pkg::t_coord'({5'b0, i_state.clip_bottom}))
                cy1 = gcdr_pkg::t_coord'({5'b0, i_state.clip_bottom});
        end
        mx0 = cx0 - ONE;
        my0 = cy0 - ONE;
        mx1 = cx1 + ONE;
        my1 = cy1 + ONE;
        if (mx0 < 0) mx0 = '0;
        if (my0 < 0) my0 = '0;
        if (mx1 >= VW) mx1 = VW - ONE;
        if (my1 >= VH) my1 = VH - ONE;
    end

    assign valid  = mod && ok && (mx0 <= mx1) && (my0 <= my1);
    assign span_w = mx1 - mx0 + ONE;
    assign span_h = my1 - my0 + ONE;

    always_comb begin
        o_result.writes_vram   = mod;
        o_result.cpu_upload    = live && is_upload;
        o_result.rect_valid    = valid;
        o_result.rect_x        = valid ? mx0[9:0] : 10'd0;
        o_result.rect_y        = valid ? my0[8:0] : 9'd0;
        o_result.rect_w        = valid ? span_w[10:0] : 11'd0;
        o_result.rect_h        = valid ? span_h[9:0] : 10'd0;
    end

endmodule

FILE: rtl/gpu_command_dirty_rect_top.sv
// Top level of the GPU command dirty-rectangle tracker.
// Instantiates gcdr_state and gcdr_rect; uses gcdr_pkg for all types.
//
// Usage:
//   Input channel (i_valid, o_stall, i_data) carries one command packet word
//   per transfer: port, word count and packet words 0 to 7. Output channel
//   (o_valid, i_stall, o_data) returns one result word per input word: the
//   write and upload flags and the clipped, margined dirty rectangle.
//   Configuration: i_cfg_we with i_cfg_wdata sets capture enable; write it
//   only while no word is in flight.
//   The accepting edge loads the input register; the classify/clip/clamp
//   result is loaded into the output register, raising o_valid, once it is free.
//   One word is taken every cycle while the receiver does not stall; the
//   rate is set by the single pass from input register to output register,
//   with draw state updated as each word leaves that pass.
//   When the receiver stalls, the result holds and one more word can still be
//   taken into the input register; after that o_stall rises.
//   Reset clears both pipeline stages, turns capture off, sets the draw area
//   to the whole of VRAM and the draw offset to zero.
module gpu_command_dirty_rect_top #(
    parameter int VRAM_WIDTH  = gcdr_pkg::DEF_VRAM_WIDTH,
    parameter int VRAM_HEIGHT = gcdr_pkg::DEF_VRAM_HEIGHT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  gcdr_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output gcdr_pkg::t_out_word o_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);

    logic                  r_in_valid;
    gcdr_pkg::t_in_word    r_in;
    logic                  r_out_valid;
    gcdr_pkg::t_out_word   r_out;
    logic                  out_free;
    logic                  advance;
    gcdr_pkg::t_draw_state draw_state;
    gcdr_pkg::t_out_word   result;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    gcdr_state #(
        .VRAM_WIDTH (VRAM_WIDTH),
        .VRAM_HEIGHT(VRAM_HEIGHT)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_step     (advance),
        .i_word     (r_in),
        .o_state    (draw_state)
    );

    gcdr_rect #(
        .VRAM_WIDTH (VRAM_WIDTH),
        .VRAM_HEIGHT(VRAM_HEIGHT)
    ) u_rect (
        .i_word  (r_in),
        .i_state (draw_state),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
